### rtl/pdnt_pkg.sv
// Types, constants and codes shared by the pairwise debt netting table.
`default_nettype none
package pdnt_pkg;

    localparam int ROWS  = 16;
    localparam int DEBTS = 64;

    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(ROWS + 1);
    localparam int DT_W  = $clog2(DEBTS + 1);

    localparam int EKEY_W = 46;
    localparam int CKEY_W = 40;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_MAT   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_CAPACITY = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_DISABLED = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_ASSET_EN  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        debtor_account;
        logic [15:0]        creditor_account;
        logic [5:0]         asset_number;
        logic [7:0]         domain_number;
        logic signed [63:0] debt_amount;
    } cmd_t;

    typedef struct packed {
        logic        is_row;
        logic        last;
        logic [2:0]  status;
        logic [15:0] net_debtor;
        logic [15:0] net_creditor;
        logic [5:0]  net_asset;
        logic [7:0]  net_domain;
        logic [62:0] net_amount;
    } result_t;

endpackage
`default_nettype wire

### rtl/pairwise_debt_netting_table_top.sv
// Pairwise debt netting table: sequencer, row stores and one shared compare/add path.
//
// One command is accepted when start is high and busy is low. An add that is
// rejected, lands in a disabled asset or finds an error pending is answered in the
// cycle after it is accepted; otherwise the row store of its kind is searched one
// key per cycle through a single compare and add path. A materialize walks the
// exact rows and then the compact rows twice, one row per cycle, first to check for
// errors and then to emit every nonzero row. Clear and unknown codes are also
// answered in the cycle after acceptance. Each result appears on result for
// exactly one cycle with result_valid high and cannot be held off; the final
// result of a command carries last. Configuration writes are always taken
// (cfg_ready is high) and must only be issued while the block is idle.
`default_nettype none
module pairwise_debt_netting_table_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pdnt_pkg::cmd_t       cmd,
    output logic                      result_valid,
    output pdnt_pkg::result_t         result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [63:0]          cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SCAN   = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    localparam logic [63:0] SIGN64 = {1'b1, 63'd0};

    state_t state_reg, state_next;
    logic [62:0] thr_reg;
    logic [63:0] mask_reg;
    logic [pdnt_pkg::DT_W-1:0]  debt_total_reg, debt_total_next;
    logic [pdnt_pkg::CNT_W-1:0] e_used_reg, e_used_next, c_used_reg, c_used_next;
    logic [2:0] pend_reg, pend_next;
    logic tbl_reg, tbl_next;
    logic [pdnt_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [pdnt_pkg::DT_W-1:0]  k_reg, k_next;
    logic [pdnt_pkg::EKEY_W-1:0] key_reg, key_next;
    logic [5:0]  asset_reg, asset_next;
    logic [63:0] v_reg, v_next;
    logic        out_valid_reg, out_valid_next;
    pdnt_pkg::result_t out_reg, out_next;

    logic [pdnt_pkg::EKEY_W-1:0] e_key [pdnt_pkg::ROWS];
    logic [63:0]                 e_net [pdnt_pkg::ROWS];
    logic [pdnt_pkg::CKEY_W-1:0] c_key [pdnt_pkg::ROWS];
    logic [5:0]                  c_set [pdnt_pkg::ROWS];
    logic [63:0]                 c_net [pdnt_pkg::ROWS];

    logic we_net, we_new;
    logic [63:0] wr_net;
    logic [pdnt_pkg::IDX_W-1:0] ridx;

    logic [pdnt_pkg::CNT_W-1:0] used_cur;
    logic in_range, key_hit, ovf, accept, bad_add;
    logic [63:0] row_net, sum, mag;
    logic [15:0] row_lo, row_hi, lo, hi;
    logic [5:0]  row_asset;
    logic [7:0]  row_dom;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign accept       = start && !busy;
    assign ridx         = idx_reg[pdnt_pkg::IDX_W-1:0];

    // Current row of the walk, shared by search, scan and emit.
    always_comb
    begin
        used_cur = tbl_reg ? c_used_reg : e_used_reg;
        in_range = (idx_reg < used_cur);
        if (tbl_reg)
        begin
            row_net   = c_net[ridx];
            row_lo    = c_key[ridx][39:24];
            row_hi    = c_key[ridx][23:8];
            row_asset = c_set[ridx];
            row_dom   = c_key[ridx][7:0];
            key_hit   = (c_key[ridx] == key_reg[pdnt_pkg::CKEY_W-1:0]);
        end
        else
        begin
            row_net   = e_net[ridx];
            row_lo    = e_key[ridx][45:30];
            row_hi    = e_key[ridx][29:14];
            row_asset = e_key[ridx][13:8];
            row_dom   = e_key[ridx][7:0];
            key_hit   = (e_key[ridx] == key_reg);
        end
        sum = row_net + v_reg;
        ovf = (row_net[63] == v_reg[63]) && (sum[63] != v_reg[63]);
        mag = 64'd0 - row_net;
    end

    always_comb
    begin
        lo      = (cmd.debtor_account < cmd.creditor_account)
                  ? cmd.debtor_account : cmd.creditor_account;
        hi      = (cmd.debtor_account < cmd.creditor_account)
                  ? cmd.creditor_account : cmd.debtor_account;
        bad_add = (cmd.debtor_account == cmd.creditor_account)
                  || (cmd.debt_amount <= 64'sd0);
    end

    always_comb
    begin
        state_next      = state_reg;
        debt_total_next = debt_total_reg;
        e_used_next     = e_used_reg;
        c_used_next     = c_used_reg;
        pend_next       = pend_reg;
        tbl_next        = tbl_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        key_next        = key_reg;
        asset_next      = asset_reg;
        v_next          = v_reg;
        out_valid_next  = 1'b0;
        out_next        = '0;
        out_next.last   = 1'b1;
        we_net          = 1'b0;
        we_new          = 1'b0;
        wr_net          = sum;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    case (pdnt_pkg::func_t'(cmd.func))
                        pdnt_pkg::FUNC_ADD:
                        begin
                            if (bad_add)
                                out_next.status = pdnt_pkg::ST_INVALID;
                            else if (debt_total_reg >= pdnt_pkg::DT_W'(pdnt_pkg::DEBTS))
                                out_next.status = pdnt_pkg::ST_CAPACITY;
                            else
                            begin
                                debt_total_next = debt_total_reg + 1'b1;
                                if (pend_reg == pdnt_pkg::ST_OK)
                                begin
                                    if (!mask_reg[cmd.asset_number])
                                        pend_next = pdnt_pkg::ST_DISABLED;
                                    else
                                    begin
                                        // Status goes out when the search ends.
                                        out_valid_next = 1'b0;
                                        tbl_next = (cmd.debt_amount <= $signed({1'b0, thr_reg}));
                                        key_next = tbl_next
                                            ? {6'd0, lo, hi, cmd.domain_number}
                                            : {lo, hi, cmd.asset_number, cmd.domain_number};
                                        asset_next = cmd.asset_number;
                                        v_next = (cmd.debtor_account == lo)
                                                 ? cmd.debt_amount
                                                 : 64'd0 - cmd.debt_amount;
                                        idx_next   = '0;
                                        state_next = S_SEARCH;
                                    end
                                end
                            end
                        end
                        pdnt_pkg::FUNC_MAT:
                        begin
                            if (pend_reg != pdnt_pkg::ST_OK)
                                out_next.status = pend_reg;
                            else
                            begin
                                out_valid_next = 1'b0;
                                tbl_next   = 1'b0;
                                idx_next   = '0;
                                k_next     = '0;
                                state_next = S_SCAN;
                            end
                        end
                        pdnt_pkg::FUNC_CLEAR:
                        begin
                            debt_total_next = '0;
                            e_used_next     = '0;
                            c_used_next     = '0;
                            pend_next       = pdnt_pkg::ST_OK;
                        end
                        default:
                            out_next.status = pdnt_pkg::ST_INVALID;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (in_range && !key_hit)
                    idx_next = idx_reg + 1'b1;
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (in_range)
                    begin
                        if (ovf)
                            pend_next = pdnt_pkg::ST_OVERFLOW;
                        else
                            we_net = 1'b1;
                    end
                    else if (used_cur >= pdnt_pkg::CNT_W'(pdnt_pkg::ROWS))
                        pend_next = pdnt_pkg::ST_CAPACITY;
                    else
                    begin
                        // A fresh row starts at zero, so the first fold cannot overflow.
                        we_net = 1'b1;
                        we_new = 1'b1;
                        wr_net = v_reg;
                        if (tbl_reg)
                            c_used_next = c_used_reg + 1'b1;
                        else
                            e_used_next = e_used_reg + 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (in_range)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (row_net != 64'd0)
                    begin
                        if (row_net == SIGN64)
                        begin
                            out_valid_next  = 1'b1;
                            out_next.status = pdnt_pkg::ST_OVERFLOW;
                            state_next      = S_IDLE;
                        end
                        else if (k_reg >= pdnt_pkg::DT_W'(pdnt_pkg::DEBTS))
                        begin
                            out_valid_next  = 1'b1;
                            out_next.status = pdnt_pkg::ST_CAPACITY;
                            state_next      = S_IDLE;
                        end
                        else
                            k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = '0;
                    tbl_next = !tbl_reg;
                    if (tbl_reg)
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (in_range)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (row_net != 64'd0)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.is_row     = 1'b1;
                        out_next.last       = 1'b0;
                        out_next.net_asset  = row_asset;
                        out_next.net_domain = row_dom;
                        if (row_net[63])
                        begin
                            out_next.net_debtor   = row_hi;
                            out_next.net_creditor = row_lo;
                            out_next.net_amount   = mag[62:0];
                        end
                        else
                        begin
                            out_next.net_debtor   = row_lo;
                            out_next.net_creditor = row_hi;
                            out_next.net_amount   = row_net[62:0];
                        end
                    end
                end
                else if (!tbl_reg)
                begin
                    idx_next = '0;
                    tbl_next = 1'b1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= '0;
            mask_reg       <= '1;
            debt_total_reg <= '0;
            e_used_reg     <= '0;
            c_used_reg     <= '0;
            pend_reg       <= pdnt_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            tbl_reg        <= 1'b0;
            idx_reg        <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            debt_total_reg <= debt_total_next;
            e_used_reg     <= e_used_next;
            c_used_reg     <= c_used_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            tbl_reg        <= tbl_next;
            idx_reg        <= idx_next;
            k_reg          <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                case (pdnt_pkg::cfg_reg_t'(cfg_index))
                    pdnt_pkg::REG_THRESHOLD: thr_reg  <= cfg_data[62:0];
                    pdnt_pkg::REG_ASSET_EN:  mask_reg <= cfg_data;
                    default:                 mask_reg <= mask_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        asset_reg <= asset_next;
        v_reg     <= v_next;
        out_reg   <= out_next;
        if (we_net)
        begin
            if (tbl_reg)
            begin
                c_net[ridx] <= wr_net;
                if (we_new)
                begin
                    c_key[ridx] <= key_reg[pdnt_pkg::CKEY_W-1:0];
                    c_set[ridx] <= asset_reg;
                end
            end
            else
            begin
                e_net[ridx] <= wr_net;
                if (we_new)
                    e_key[ridx] <= key_reg;
            end
        end
    end

    a_row_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.is_row) |-> (out_reg.status == 3'd0 && !out_reg.last))
        else $error("row result carries a status or last");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (e_used_reg <= pdnt_pkg::CNT_W'(pdnt_pkg::ROWS))
        && (c_used_reg <= pdnt_pkg::CNT_W'(pdnt_pkg::ROWS)))
        else $error("row count beyond store depth");
    a_done_with_status: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (out_valid_reg && out_reg.last && !out_reg.is_row))
        else $error("command ended without a final status");
    a_idle_no_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !$past(busy)) |-> !(out_valid_reg && out_reg.is_row))
        else $error("row result outside a materialize");

endmodule
`default_nettype wire
